// File: src/lidar_range_to_xyz_top_macros.svh
// Assertion macros for the lidar range-to-xyz RTL.
`ifndef LIDAR_RANGE_TO_XYZ_TOP_MACROS_SVH
`define LIDAR_RANGE_TO_XYZ_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LRX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the trigger.
`define LRX_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lrx_pkg.sv
// Shared constants, types and helper functions for the lidar range-to-xyz block.
package lrx_pkg;

   localparam int unsigned MAX_RAYS        = 65536;
   localparam int unsigned TRIG_ITERATIONS = 16;
   localparam int unsigned ATAN_LEN        = 24;

   localparam int unsigned RANGE_W = 24;
   localparam int unsigned CNT_W   = 17;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned OUT_W   = 25;
   localparam int unsigned TRIG_W  = 17;
   localparam int unsigned ANGLE_W = 32;
   localparam int unsigned CW      = 34;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOV_H     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOV_V     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX = 3'd5;

   localparam logic [RANGE_W-1:0] NO_RETURN   = 24'hFF_FFFF;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [CW-1:0] cordic_word_type;

   typedef logic [ANGLE_W-1:0] atan_table_type [ATAN_LEN];
   localparam atan_table_type ATAN_TURN = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // Round a Q3.30 value to Q1.15 and clamp to +-1.0.
   function automatic logic signed [TRIG_W-1:0] to_q15(input cordic_word_type v);
      logic signed [CW-1:0] r;
      r = (v + cordic_word_type'(34'sd16384)) >>> 15;
      if (r > 34'sd32768)
         return 17'sd32768;
      else if (r < -34'sd32768)
         return -17'sd32768;
      else
         return r[TRIG_W-1:0];
   endfunction

endpackage

// File: src/lrx_if.sv
// Valid/ready channel interfaces for the range samples and the xyz points.
interface lrx_req_if;
   import lrx_pkg::*;
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] range;
   logic               start_of_frame;
   modport source (output valid, range, start_of_frame, input ready);
   modport sink (input valid, range, start_of_frame, output ready);
endinterface

interface lrx_rsp_if;
   import lrx_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] x;
   logic signed [OUT_W-1:0] y;
   logic signed [OUT_W-1:0] z;
   logic [POS_W-1:0]        row;
   logic [POS_W-1:0]        column;
   modport source (output valid, x, y, z, row, column, input ready);
   modport sink (input valid, x, y, z, row, column, output ready);
endinterface

// File: src/lidar_range_to_xyz_top.sv
// Lidar range samples in row-major order to x, y, z points through CORDIC cell chains.
// A kept sample passes the 56-step bit-serial angle dividers, the 16-cell CORDIC chains, then
// the trig, multiply and output states; a dropped sample only advances the position.
// One sample at a time: the next is taken only once the point is loaded into the result register,
// which waits on a stalled receiver.
// Reset (synchronous, active high) clears position, control state and configuration registers to defaults.
`include "lidar_range_to_xyz_top_macros.svh"
module lidar_range_to_xyz_top
   import lrx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lrx_req_if.sink                req_chan,
   lrx_rsp_if.source              rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [RANGE_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_CORDIC, ST_TRIG, ST_MUL1, ST_MUL2, ST_OUT
   } state_type;

   localparam int unsigned ITER_W = $clog2(TRIG_ITERATIONS);
   localparam int unsigned PW = 42;
   localparam int unsigned XW = 60;

   state_type             state_ff;
   logic [CNT_W-1:0]      columns_ff, rows_ff, fov_h_ff, fov_v_ff;
   logic [RANGE_W-1:0]    range_min_ff, range_max_ff;
   logic [POS_W-1:0]      col_pos_ff, row_pos_ff, cur_col_ff, cur_row_ff;
   logic [RANGE_W-1:0]    range_ff;
   logic [ITER_W-1:0]     iter_ff;
   logic signed [TRIG_W-1:0] elevation_sine_ff, elevation_cosine_ff, az_sin_ff, az_cos_ff;
   logic signed [PW-1:0]  p_ff, zp_ff;
   logic signed [XW-1:0]  xp_ff, yp_ff;
   logic                  rsp_valid_ff;
   logic signed [OUT_W-1:0] x_ff, y_ff, z_ff;
   logic [POS_W-1:0]      row_out_ff, col_out_ff;

   logic                  accept, emit, frame_ok, hit;
   logic [POS_W-1:0]      col_eff, row_eff;
   logic [CNT_W-1:0]      col_next, row_next;
   logic [2*CNT_W-1:0]    ray_count;
   logic [RANGE_W:0]      range_top;
   logic [ANGLE_W-1:0]    el_angle, az_angle;
   logic                  el_done, az_done, div_start;
   logic                  el_flip, az_flip;
   logic [ANGLE_W-1:0]    el_rot, az_rot;
   logic signed [XW-1:0]  x_rnd, y_rnd;
   logic signed [PW-1:0]  z_rnd;
   logic signed [OUT_W-1:0] x_sat, y_sat, z_sat;

   cordic_word_type el_x [TRIG_ITERATIONS+1];
   cordic_word_type el_y [TRIG_ITERATIONS+1];
   cordic_word_type el_z [TRIG_ITERATIONS+1];
   cordic_word_type az_x [TRIG_ITERATIONS+1];
   cordic_word_type az_y [TRIG_ITERATIONS+1];
   cordic_word_type az_z [TRIG_ITERATIONS+1];

   // Sample classification and position bookkeeping.
   always_comb begin
      accept    = req_chan.valid && req_chan.ready;
      col_eff   = req_chan.start_of_frame ? '0 : col_pos_ff;
      row_eff   = req_chan.start_of_frame ? '0 : row_pos_ff;
      col_next  = {1'b0, col_eff} + 17'd1;
      row_next  = {1'b0, row_eff} + 17'd1;
      ray_count = columns_ff * rows_ff;
      frame_ok  = (columns_ff != '0) && (columns_ff <= 17'd65536) && (rows_ff != '0)
                  && (rows_ff <= 17'd65536) && (ray_count <= 34'(MAX_RAYS));
      range_top = {1'b0, req_chan.range} + 25'd7;
      hit = (req_chan.range != '0) && (req_chan.range != NO_RETURN)
            && (req_chan.range >= range_min_ff)
            && !((range_max_ff != NO_RETURN) && (range_top >= {1'b0, range_max_ff}));
      emit      = frame_ok && hit;
      div_start = accept && emit;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   lrx_angle_div u_el_div (
      .clock (clock), .reset (reset), .start (div_start),
      .fov (fov_v_ff), .count (rows_ff), .index (row_eff),
      .angle (el_angle), .done (el_done)
   );

   lrx_angle_div u_az_div (
      .clock (clock), .reset (reset), .start (div_start),
      .fov (fov_h_ff), .count (columns_ff), .index (col_eff),
      .angle (az_angle), .done (az_done)
   );

   // Fold angles in the left half plane by a half turn; negate the results later.
   always_comb begin
      el_flip = el_angle[31] ^ el_angle[30];
      az_flip = az_angle[31] ^ az_angle[30];
      el_rot  = el_flip ? (el_angle + 32'h8000_0000) : el_angle;
      az_rot  = az_flip ? (az_angle + 32'h8000_0000) : az_angle;
   end

   assign el_x[0] = CORDIC_GAIN;
   assign el_y[0] = '0;
   assign el_z[0] = cordic_word_type'($signed(el_rot));
   assign az_x[0] = CORDIC_GAIN;
   assign az_y[0] = '0;
   assign az_z[0] = cordic_word_type'($signed(az_rot));

   for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cell
      lrx_cordic_cell u_el_cell (
         .clock (clock), .x_in (el_x[i]), .y_in (el_y[i]), .z_in (el_z[i]),
         .shift (SHIFT_W'(i)), .atan (ATAN_TURN[i]),
         .x_out (el_x[i+1]), .y_out (el_y[i+1]), .z_out (el_z[i+1])
      );
      lrx_cordic_cell u_az_cell (
         .clock (clock), .x_in (az_x[i]), .y_in (az_y[i]), .z_in (az_z[i]),
         .shift (SHIFT_W'(i)), .atan (ATAN_TURN[i]),
         .x_out (az_x[i+1]), .y_out (az_y[i+1]), .z_out (az_z[i+1])
      );
   end

   // Round and saturate the products to Q8.16.
   always_comb begin
      x_rnd = (xp_ff + XW'(64'sd536870912)) >>> 30;
      y_rnd = (yp_ff + XW'(64'sd536870912)) >>> 30;
      z_rnd = (zp_ff + PW'(64'sd16384)) >>> 15;
      x_sat = (x_rnd > XW'(64'sd16777215)) ? 25'sd16777215 :
              (x_rnd < -XW'(64'sd16777216)) ? -25'sd16777216 : x_rnd[OUT_W-1:0];
      y_sat = (y_rnd > XW'(64'sd16777215)) ? 25'sd16777215 :
              (y_rnd < -XW'(64'sd16777216)) ? -25'sd16777216 : y_rnd[OUT_W-1:0];
      z_sat = (z_rnd > PW'(64'sd16777215)) ? 25'sd16777215 :
              (z_rnd < -PW'(64'sd16777216)) ? -25'sd16777216 : z_rnd[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         columns_ff   <= 17'd1;
         rows_ff      <= 17'd1;
         fov_h_ff     <= '0;
         fov_v_ff     <= '0;
         range_min_ff <= '0;
         range_max_ff <= NO_RETURN;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         elevation_sine_ff   <= '0;
         elevation_cosine_ff <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_COLUMNS:   columns_ff   <= csr_wdata[CNT_W-1:0];
               CSR_ROWS:      rows_ff      <= csr_wdata[CNT_W-1:0];
               CSR_FOV_H:     fov_h_ff     <= csr_wdata[CNT_W-1:0];
               CSR_FOV_V:     fov_v_ff     <= csr_wdata[CNT_W-1:0];
               CSR_RANGE_MIN: range_min_ff <= csr_wdata;
               CSR_RANGE_MAX: range_max_ff <= csr_wdata;
               default: ;
            endcase
         end
         // drop the beat once taken, unless a new point loads this cycle
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_OUT))
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cur_col_ff <= col_eff;
                  cur_row_ff <= row_eff;
                  range_ff   <= req_chan.range;
                  // advance column, wrap into the next row, and from the last row back to row 0
                  if (col_next >= columns_ff) begin
                     col_pos_ff <= '0;
                     row_pos_ff <= (row_next >= rows_ff) ? '0 : row_next[POS_W-1:0];
                  end else begin
                     col_pos_ff <= col_next[POS_W-1:0];
                     row_pos_ff <= row_eff;
                  end
                  if (emit)
                     state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (el_done) begin
                  iter_ff  <= '0;
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == ITER_W'(TRIG_ITERATIONS - 1))
                  state_ff <= ST_TRIG;
            end
            ST_TRIG: begin
               elevation_sine_ff   <= to_q15(el_flip ? -el_y[TRIG_ITERATIONS] : el_y[TRIG_ITERATIONS]);
               elevation_cosine_ff <= to_q15(el_flip ? -el_x[TRIG_ITERATIONS] : el_x[TRIG_ITERATIONS]);
               az_sin_ff <= to_q15(az_flip ? -az_y[TRIG_ITERATIONS] : az_y[TRIG_ITERATIONS]);
               az_cos_ff <= to_q15(az_flip ? -az_x[TRIG_ITERATIONS] : az_x[TRIG_ITERATIONS]);
               state_ff  <= ST_MUL1;
            end
            ST_MUL1: begin
               p_ff     <= PW'($signed({1'b0, range_ff})) * PW'(elevation_cosine_ff);
               zp_ff    <= PW'($signed({1'b0, range_ff})) * PW'(elevation_sine_ff);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               xp_ff    <= XW'(p_ff) * XW'(az_cos_ff);
               yp_ff    <= XW'(p_ff) * XW'(az_sin_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  x_ff         <= x_sat;
                  y_ff         <= y_sat;
                  z_ff         <= z_sat;
                  row_out_ff   <= cur_row_ff;
                  col_out_ff   <= cur_col_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.x      = x_ff;
   assign rsp_chan.y      = y_ff;
   assign rsp_chan.z      = z_ff;
   assign rsp_chan.row    = row_out_ff;
   assign rsp_chan.column = col_out_ff;

   `LRX_ASSERT(a_accept_idle, !accept || (state_ff == ST_IDLE), "beat accepted while busy")
   `LRX_ASSERT(a_div_lockstep, el_done == az_done, "angle dividers out of step")
   `LRX_ASSERT(a_done_in_div, !el_done || (state_ff == ST_DIV), "divider done outside wait")
   `LRX_ASSERT_NEXT(a_rsp_hold, rsp_valid_ff && !rsp_chan.ready, rsp_valid_ff,
                    "pending point lost")

endmodule

// File: src/lrx_angle_div.sv
// Beam angle unit: rounded fov*(count-1-2*index)*2^21 / (90*(count-1)), one bit a cycle.
module lrx_angle_div
   import lrx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CNT_W-1:0]    fov,
   input  logic [CNT_W-1:0]    count,
   input  logic [POS_W-1:0]    index,
   output logic [ANGLE_W-1:0]  angle,
   output logic                done
);

   localparam int unsigned NUM_W  = 56;
   localparam int unsigned DEN_W  = 24;
   localparam int unsigned PROD_W = 2 * CNT_W;
   localparam int unsigned BIT_W  = $clog2(NUM_W);

   typedef enum logic [1:0] {D_IDLE, D_MUL, D_RUN, D_DONE} div_state_type;

   div_state_type        state_ff;
   logic                 zero_ff, neg_ff, done_ff;
   logic [CNT_W-1:0]     fov_ff, mag_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [ANGLE_W-1:0]   quo_ff, angle_ff;
   logic [BIT_W-1:0]     bit_ff;

   logic [CNT_W-1:0]     cm1;
   logic signed [CNT_W+1:0] n_val;
   logic [CNT_W+1:0]     n_abs;
   logic [DEN_W:0]       trial;
   logic                 qbit;
   logic [DEN_W-1:0]     rem_in;

   always_comb begin
      cm1   = count - 17'd1;
      n_val = $signed({2'b00, cm1}) - $signed({2'b00, index, 1'b0});
      n_abs = n_val[CNT_W+1] ? 19'(-n_val) : 19'(n_val);
      trial = {rem_ff, num_ff[NUM_W-1]};
      qbit  = trial >= {1'b0, den_ff};
      rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  zero_ff  <= count <= 17'd1;
                  neg_ff   <= n_val[CNT_W+1];
                  mag_ff   <= n_abs[CNT_W-1:0];
                  fov_ff   <= fov;
                  den_ff   <= DEN_W'(cm1) * DEN_W'(7'd90);
                  state_ff <= D_MUL;
               end
            end
            D_MUL: begin
               num_ff   <= NUM_W'({PROD_W'(fov_ff) * PROD_W'(mag_ff), 21'd0})
                           + NUM_W'(den_ff >> 1);
               rem_ff   <= '0;
               quo_ff   <= '0;
               bit_ff   <= BIT_W'(NUM_W - 1);
               state_ff <= D_RUN;
            end
            D_RUN: begin
               rem_ff <= rem_in;
               num_ff <= {num_ff[NUM_W-2:0], 1'b0};
               quo_ff <= {quo_ff[ANGLE_W-2:0], qbit};
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0)
                  state_ff <= D_DONE;
            end
            D_DONE: begin
               angle_ff <= zero_ff ? '0 : (neg_ff ? (~quo_ff + 1'b1) : quo_ff);
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign angle = angle_ff;
   assign done  = done_ff;

endmodule

// File: src/lrx_cordic_cell.sv
// One rotation step of the CORDIC chain, registered toward the next cell.
module lrx_cordic_cell
   import lrx_pkg::*;
(
   input  logic                clock,
   input  cordic_word_type     x_in,
   input  cordic_word_type     y_in,
   input  cordic_word_type     z_in,
   input  logic [SHIFT_W-1:0]  shift,
   input  logic [ANGLE_W-1:0]  atan,
   output cordic_word_type     x_out,
   output cordic_word_type     y_out,
   output cordic_word_type     z_out
);

   cordic_word_type x_ff, y_ff, z_ff;
   cordic_word_type x_sh, y_sh, atan_ext;

   always_comb begin
      x_sh     = x_in >>> shift;
      y_sh     = y_in >>> shift;
      atan_ext = cordic_word_type'({2'b00, atan});
   end

   always_ff @(posedge clock) begin
      if (!z_in[CW-1]) begin
         x_ff <= x_in - y_sh;
         y_ff <= y_in + x_sh;
         z_ff <= z_in - atan_ext;
      end else begin
         x_ff <= x_in + y_sh;
         y_ff <= y_in - x_sh;
         z_ff <= z_in + atan_ext;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

// File: tb/lidar_range_to_xyz_top_tb.sv
// Self-checking testbench for the lidar range-to-xyz block: predicted points against the result channel.
module lidar_range_to_xyz_top_tb;
   import lrx_pkg::*;

   typedef struct packed {
      logic [RANGE_W-1:0] range;
      logic               sof;
   } sample_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        column;
   } point_type;

   localparam int LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_COLUMNS;
   logic [RANGE_W-1:0]   csr_wdata = '0;

   lrx_req_if req_chan();
   lrx_rsp_if rsp_chan();

   lidar_range_to_xyz_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [16:0] m_cols, m_rows, m_fovh, m_fovv;
   logic [23:0] m_rmin, m_rmax;
   logic [15:0] m_col, m_row;

   sample_type pending_samples[$];
   point_type  expected_points[$];
   int      errors = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.range = '0;
      req_chan.start_of_frame = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [31:0] beam_angle(logic [16:0] fov, logic [16:0] count,
                                              logic [15:0] index);
      longint n;
      longint unsigned mag, num, den, q;
      if (count <= 1) return 32'd0;
      n = longint'(count) - 1 - 2 * longint'(index);
      mag = (n < 0) ? -n : n;
      num = (longint'(fov) * mag) << 21;
      den = 90 * (longint'(count) - 1);
      q = (num + den / 2) / den;
      if (n < 0) q = -q;
      return q[31:0];
   endfunction

   function automatic longint round_q15(longint v);
      longint r;
      r = shr_floor(v + 16384, 15);
      if (r > 32768) r = 32768;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   task automatic cordic_trig(input logic [31:0] ang_in, output longint sn, output longint cs);
      logic [31:0] ang;
      bit flip;
      longint x, y, z, nx;
      ang = ang_in;
      flip = 0;
      x = 652032874;
      y = 0;
      if (((ang + 32'h40000000) & 32'h80000000) != 0) begin
         ang = ang + 32'h80000000;
         flip = 1;
      end
      z = longint'(signed'(ang));
      for (int i = 0; i < TRIG_ITERATIONS; i++) begin
         if (z >= 0) begin
            nx = x - shr_floor(y, i);
            y = y + shr_floor(x, i);
            z = z - longint'(ATAN_TURN[i]);
         end else begin
            nx = x + shr_floor(y, i);
            y = y - shr_floor(x, i);
            z = z + longint'(ATAN_TURN[i]);
         end
         x = nx;
      end
      sn = round_q15(flip ? -y : y);
      cs = round_q15(flip ? -x : x);
   endtask

   function automatic logic [OUT_W-1:0] sat25(longint v);
      if (v > 16777215) v = 16777215;
      if (v < -16777216) v = -16777216;
      return v[OUT_W-1:0];
   endfunction

   task automatic predict_point(input sample_type s);
      bit frame_ok, hit;
      longint es, ec, sa, ca, p;
      point_type pt;
      if (s.sof) begin
         m_col = '0;
         m_row = '0;
      end
      frame_ok = m_cols >= 1 && m_cols <= 65536 && m_rows >= 1 && m_rows <= 65536
                 && longint'(m_cols) * longint'(m_rows) <= MAX_RAYS;
      cordic_trig(beam_angle(m_fovv, m_rows, m_row), es, ec);
      hit = s.range != 0 && s.range != NO_RETURN && s.range >= m_rmin;
      if (m_rmax != 24'hFFFFFF && longint'(s.range) + 7 >= longint'(m_rmax)) hit = 0;
      if (frame_ok && hit) begin
         cordic_trig(beam_angle(m_fovh, m_cols, m_col), sa, ca);
         p = longint'(s.range) * ec;
         pt.x = sat25(shr_floor(p * ca + (longint'(1) << 29), 30));
         pt.y = sat25(shr_floor(p * sa + (longint'(1) << 29), 30));
         pt.z = sat25(shr_floor(longint'(s.range) * es + 16384, 15));
         pt.row = m_row;
         pt.column = m_col;
         expected_points.insert(expected_points.size(), pt);
      end
      if (longint'(m_col) + 1 >= longint'(m_cols)) begin
         m_col = '0;
         if (longint'(m_row) + 1 >= longint'(m_rows)) m_row = '0;
         else m_row = m_row + 1'b1;
      end else begin
         m_col = m_col + 1'b1;
      end
   endtask

   // driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_point({req_chan.range, req_chan.start_of_frame});
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid <= 1'b1;
               req_chan.range <= pending_samples[0].range;
               req_chan.start_of_frame <= pending_samples[0].sof;
               void'(pending_samples.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d z=%0d", $realtime,
                     rsp_chan.x, rsp_chan.y, rsp_chan.z);
            errors <= errors + 1;
         end else begin
            want = expected_points.pop_front();
            if (want.x !== rsp_chan.x || want.y !== rsp_chan.y || want.z !== rsp_chan.z ||
                want.row !== rsp_chan.row || want.column !== rsp_chan.column) begin
               $display("%0t: expected x=%0d y=%0d z=%0d r=%0d c=%0d, got x=%0d y=%0d z=%0d r=%0d c=%0d",
                        $realtime, want.x, want.y, want.z, want.row, want.column,
                        rsp_chan.x, rsp_chan.y, rsp_chan.z, rsp_chan.row, rsp_chan.column);
               errors <= errors + 1;
            end
         end
      end
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (cycle_count >= LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_chan.valid || expected_points.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // one write beat, then write enable drops before the next write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_COLUMNS:   m_cols = val[16:0];
         CSR_ROWS:      m_rows = val[16:0];
         CSR_FOV_H:     m_fovh = val[16:0];
         CSR_FOV_V:     m_fovv = val[16:0];
         CSR_RANGE_MIN: m_rmin = val;
         CSR_RANGE_MAX: m_rmax = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [23:0] rand_range();
      case ($urandom_range(9))
         0: return 24'd0;
         1: return NO_RETURN;
         2: return 24'hFFFFFE - 24'($urandom_range(15));
         3: return 24'($urandom_range(31));
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic config_phase(input int ph);
      logic [16:0] c, r;
      case (ph % 6)
         0: begin c = 17'd65536; r = 17'd1; end
         1: begin c = 17'd1; r = 17'd65536; end
         2: begin c = 17'd256; r = 17'd256; end
         3: begin c = 17'd300; r = 17'd300; end
         default: begin c = 17'($urandom_range(1, 40)); r = 17'($urandom_range(1, 40)); end
      endcase
      write_reg(CSR_COLUMNS, 24'(c));
      write_reg(CSR_ROWS, 24'(r));
      write_reg(CSR_FOV_H, (ph % 3 == 0) ? 24'd92160 : 24'($urandom_range(92160)));
      write_reg(CSR_FOV_V, (ph % 3 == 1) ? 24'd92160 : 24'($urandom_range(92160)));
      write_reg(CSR_RANGE_MIN, (ph % 4 == 0) ? 24'd0 : 24'($urandom_range(4095)));
      write_reg(CSR_RANGE_MAX, (ph % 4 == 0) ? 24'hFFFFFF :
                (ph % 4 == 1) ? 24'd3 : 24'hF00000 + 24'($urandom_range(65535)));
   endtask

   initial begin
      sample_type s;
      m_cols = 17'd1; m_rows = 17'd1; m_fovh = '0; m_fovv = '0;
      m_rmin = '0; m_rmax = 24'hFFFFFF; m_col = '0; m_row = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: reset defaults, then a small frame with edge ranges
      pending_samples.insert(pending_samples.size(), {24'd0, 1'b1});
      pending_samples.insert(pending_samples.size(), {NO_RETURN, 1'b0});
      pending_samples.insert(pending_samples.size(), {24'hFFFFFE, 1'b0});
      pending_samples.insert(pending_samples.size(), {24'd1, 1'b0});
      wait_idle();
      write_reg(CSR_COLUMNS, 24'd3);
      write_reg(CSR_ROWS, 24'd3);
      write_reg(CSR_FOV_H, 24'd92160);
      write_reg(CSR_FOV_V, 24'd7680);
      write_reg(CSR_RANGE_MIN, 24'd100);
      write_reg(CSR_RANGE_MAX, 24'd200000);
      for (int i = 0; i < 12; i++) begin
         s.sof = (i == 0);
         s.range = (i == 2) ? 24'd99 : (i == 3) ? 24'd100 : (i == 4) ? 24'd199993 :
                   (i == 5) ? 24'd199992 : 24'd1000 + 24'(i) * 24'd9000;
         pending_samples.insert(pending_samples.size(), s);
      end
      wait_idle();
      // frame too large: everything dropped, position still advances
      write_reg(CSR_ROWS, 24'd30000);
      for (int i = 0; i < 4; i++)
         pending_samples.insert(pending_samples.size(), {24'd5000, 1'b0});
      wait_idle();
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         config_phase(ph);
         for (int i = 0; i < 75; i++) begin
            s.sof = (i == 0) || ($urandom_range(49) == 0);
            s.range = rand_range();
            pending_samples.insert(pending_samples.size(), s);
         end
         wait_idle();
      end
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: lidar_range_to_xyz_top.f
+incdir+src
src/lrx_pkg.sv
src/lrx_if.sv
src/lrx_angle_div.sv
src/lrx_cordic_cell.sv
src/lidar_range_to_xyz_top.sv
tb/lidar_range_to_xyz_top_tb.sv
